>>> rtl/itod_pkg.sv
// Shared types, constants and helpers for the integer to decimal text block.
// Used by itod_bcd_conv and integer_to_decimal_text; depends on nothing else.
package itod_pkg;

    localparam int MAG_W    = 64;
    localparam int DIGITS   = 20;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int STEP_W   = $clog2(MAG_W);
    localparam int NDIG_W   = $clog2(DIGITS + 1);

    // Type selector codes
    localparam logic [1:0] FUNC_S32 = 2'd0;
    localparam logic [1:0] FUNC_S64 = 2'd1;
    localparam logic [1:0] FUNC_U32 = 2'd2;
    localparam logic [1:0] FUNC_U64 = 2'd3;

    localparam logic [6:0] BUF_CAP     = 7'd64;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic signed [5:0] LEN_NONE = -6'sd1;

    typedef logic [BCD_W-1:0] bcd_t;

    // Double-dabble correction: every digit of five or more gets three added.
    function automatic bcd_t bcd_adjust(input bcd_t bcd_in);
        bcd_t res;
        res = bcd_in;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_in[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/itod_bcd_conv.sv
// Bit-serial binary to BCD converter with leading-zero trim.
// Depends on itod_pkg (widths, bcd_t and the bcd_adjust helper).
module itod_bcd_conv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [itod_pkg::MAG_W-1:0]    mag,
    output logic                          done,
    output itod_pkg::bcd_t                bcd,
    output logic [itod_pkg::NDIG_W-1:0]   ndig
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_DABBLE,
        C_TRIM
    } conv_state_t;

    conv_state_t                        state_reg;
    logic [itod_pkg::MAG_W-1:0]         mag_reg;
    itod_pkg::bcd_t                     bcd_reg;
    logic [itod_pkg::STEP_W-1:0]        step_reg;
    logic [itod_pkg::NDIG_W-1:0]        ndig_reg;
    logic                               done_reg;
    itod_pkg::bcd_t                     bcd_adj;

    assign bcd_adj = itod_pkg::bcd_adjust(bcd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                C_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        mag_reg   <= mag;
                        bcd_reg   <= '0;
                        step_reg  <= '0;
                        ndig_reg  <= itod_pkg::NDIG_W'(itod_pkg::DIGITS);
                        state_reg <= C_DABBLE;
                    end
                end
                C_DABBLE: begin
                    done_reg <= 1'b0;
                    // One magnitude bit moves into the BCD word per cycle.
                    bcd_reg  <= {bcd_adj[itod_pkg::BCD_W-2:0], mag_reg[itod_pkg::MAG_W-1]};
                    mag_reg  <= {mag_reg[itod_pkg::MAG_W-2:0], 1'b0};
                    step_reg <= step_reg + itod_pkg::STEP_W'(1);
                    if (step_reg == itod_pkg::STEP_W'(itod_pkg::MAG_W - 1)) begin
                        state_reg <= C_TRIM;
                    end
                end
                C_TRIM: begin
                    // Drop one leading zero digit per cycle, keeping at least one.
                    if (bcd_reg[itod_pkg::BCD_W-1 -: 4] == 4'd0 &&
                        ndig_reg > itod_pkg::NDIG_W'(1)) begin
                        done_reg <= 1'b0;
                        bcd_reg  <= {bcd_reg[itod_pkg::BCD_W-5:0], 4'd0};
                        ndig_reg <= ndig_reg - itod_pkg::NDIG_W'(1);
                    end else begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default: begin
                    done_reg  <= 1'b0;
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;
    assign ndig = ndig_reg;

endmodule

>>> rtl/integer_to_decimal_text.sv
// Integer to decimal text: top level with result sequencer and output register.
// The first result follows the input transfer after the bit-serial conversion, the leading-zero
// trim, the copy into the sequencer and the output register; then one result per cycle while
// m_ready is high. No new input is taken until the last result (up to 21 results) is loaded.
// A zero-size buffer gives its single result the next cycle.
// Reset (aresetn, synchronous, active low) clears the sequencer and output valid.
module integer_to_decimal_text (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [63:0]        s_value,
    input  logic [6:0]         s_buf_len,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_last,
    output logic signed [5:0]  m_length
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } seq_state_t;

    seq_state_t                         state_reg;
    logic                               neg_reg;
    logic [5:0]                         room_reg;
    itod_pkg::bcd_t                     text_reg;
    logic [4:0]                         cnt_reg;
    logic [4:0]                         total_reg;
    logic                               m_valid_reg;
    logic [7:0]                         m_out_byte_reg;
    logic                               m_byte_valid_reg;
    logic                               m_last_reg;
    logic signed [5:0]                  m_length_reg;

    logic                               out_free;
    logic                               out_load;
    logic                               accept;
    logic                               in_neg;
    logic [itod_pkg::MAG_W-1:0]         in_mag;
    logic [6:0]                         blen_sat;
    logic                               conv_done;
    itod_pkg::bcd_t                     conv_bcd;
    logic [itod_pkg::NDIG_W-1:0]        conv_ndig;
    logic [4:0]                         chars;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign blen_sat = (s_buf_len > itod_pkg::BUF_CAP) ? itod_pkg::BUF_CAP : s_buf_len;
    // The output register takes a new result on a zero-size transfer or on each emit step.
    assign out_load = (accept && (s_buf_len == 7'd0)) || ((state_reg == S_EMIT) && out_free);

    always_comb begin
        in_neg = 1'b0;
        unique case (s_func)
            itod_pkg::FUNC_S32: begin
                in_neg = s_value[31];
                in_mag = {32'd0, in_neg ? (~s_value[31:0] + 32'd1) : s_value[31:0]};
            end
            itod_pkg::FUNC_S64: begin
                in_neg = s_value[63];
                in_mag = in_neg ? (~s_value + 64'd1) : s_value;
            end
            itod_pkg::FUNC_U32: in_mag = {32'd0, s_value[31:0]};
            itod_pkg::FUNC_U64: in_mag = s_value;
            default:            in_mag = s_value;
        endcase
    end

    itod_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (s_buf_len != 7'd0)),
        .mag     (in_mag),
        .done    (conv_done),
        .bcd     (conv_bcd),
        .ndig    (conv_ndig)
    );

    assign chars = 5'(conv_ndig) + {4'd0, neg_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_buf_len == 7'd0) begin
                            m_out_byte_reg   <= itod_pkg::ASCII_NUL;
                            m_byte_valid_reg <= 1'b0;
                            m_last_reg       <= 1'b1;
                            m_length_reg     <= itod_pkg::LEN_NONE;
                        end else begin
                            neg_reg   <= in_neg;
                            room_reg  <= 6'(blen_sat - 7'd1);
                            state_reg <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        text_reg  <= conv_bcd;
                        cnt_reg   <= '0;
                        total_reg <= ({1'b0, chars} < room_reg) ? chars : room_reg[4:0];
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_byte_valid_reg <= 1'b1;
                        if (cnt_reg == total_reg) begin
                            // Terminator carries the count of characters written.
                            m_out_byte_reg <= itod_pkg::ASCII_NUL;
                            m_last_reg     <= 1'b1;
                            m_length_reg   <= $signed({1'b0, cnt_reg});
                            state_reg      <= S_IDLE;
                        end else begin
                            m_last_reg   <= 1'b0;
                            m_length_reg <= '0;
                            cnt_reg      <= cnt_reg + 5'd1;
                            if (neg_reg) begin
                                m_out_byte_reg <= itod_pkg::ASCII_MINUS;
                                neg_reg        <= 1'b0;
                            end else begin
                                m_out_byte_reg <= {itod_pkg::ASCII_DIGIT_HI,
                                                   text_reg[itod_pkg::BCD_W-1 -: 4]};
                                text_reg       <= {text_reg[itod_pkg::BCD_W-5:0], 4'd0};
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_byte_valid = m_byte_valid_reg;
    assign m_last       = m_last_reg;
    assign m_length     = m_length_reg;

    // Character transfers are always written bytes with a zero length field.
    a_char_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_byte_valid && m_length == 6'sd0)
        else $error("character result with bad flags");

    // A written terminator is a zero byte with a length between 0 and 20.
    a_term_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last && m_byte_valid |->
            m_out_byte == itod_pkg::ASCII_NUL && m_length >= 6'sd0 && m_length <= 6'sd20)
        else $error("terminator result out of range");

    // A conversion keeps the input side closed in the following cycle.
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_buf_len != 7'd0 |=> !s_ready)
        else $error("input accepted during conversion");

    // The emit counter never runs past the number of characters to write.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> cnt_reg <= total_reg)
        else $error("emit counter overran");

endmodule
